@@ sv/cpt_pkg.sv @@
// ---------------------------------------------------------------------------
// cpt_pkg
// shared widths, angle constants, head code constants and the cordic table
// ---------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  localparam int POS_W   = 24;   // position fields and registers
  localparam int DIFF_W  = 25;   // target minus camera
  localparam int MAG_W   = 24;   // magnitude of a difference
  localparam int SQ_W    = 62;   // radicand of the horizontal distance
  localparam int ROOT_W  = 31;   // horizontal distance, mm*64
  localparam int CX_W    = 36;   // cordic x and y
  localparam int CZ_W    = 25;   // cordic angle, degrees*65536
  localparam int ANG_W   = 15;   // first quadrant angle, degrees*256
  localparam int PAN_W   = 17;
  localparam int TILT_W  = 16;
  localparam int CODE_W  = 16;
  localparam int MOUNT_W = 17;

  localparam int DEG90      = 23040;
  localparam int DEG180     = 46080;
  localparam int DEG360     = 92160;
  localparam int DEG90_FINE = 5898240;

  // pan head code
  localparam int PAN_BASE = 'hF8D4;
  localparam int PAN_OFF  = 175;
  localparam int PAN_SPAN = 'hA5EC;
  localparam int PAN_ZERO = 'h2D09;
  // tilt head code
  localparam int TILT_BASE = 'hAAA0;
  localparam int TILT_OFF  = 30;
  localparam int TILT_SPAN = 'h71C7;
  localparam int TILT_ZERO = 'h1C71;
  localparam int CODE_SLOPE = 182;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT = 2'd3;

  // atan(2^-i) in degrees*65536, rounded
  function automatic logic signed [CZ_W-1:0] atan_tab(input int i);
    logic signed [CZ_W-1:0] v;
    case (i)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117304;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/cpt_in_if.sv @@
// ---------------------------------------------------------------------------
// cpt_in_if
// target position channel, valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface cpt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cpt_pkg::POS_W-1:0]    target_x;
  logic signed [cpt_pkg::POS_W-1:0]    target_y;
  logic signed [cpt_pkg::POS_W-1:0]    target_z;

  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

`default_nettype wire

@@ sv/cpt_out_if.sv @@
// ---------------------------------------------------------------------------
// cpt_out_if
// pan/tilt result channel, valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface cpt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cpt_pkg::PAN_W-1:0]    pan_deg;
  logic signed [cpt_pkg::TILT_W-1:0]   tilt_deg;
  logic        [cpt_pkg::CODE_W-1:0]   pan_code;
  logic        [cpt_pkg::CODE_W-1:0]   tilt_code;

  modport source (output valid, pan_deg, tilt_deg, pan_code, tilt_code, input ready);
  modport sink   (input valid, pan_deg, tilt_deg, pan_code, tilt_code, output ready);
endinterface

`default_nettype wire

@@ sv/camera_pan_tilt_pointing.sv @@
// ---------------------------------------------------------------------------
// camera_pan_tilt_pointing
// pan and tilt angles and head codes that aim a camera at a target position
// ---------------------------------------------------------------------------
// One result transaction per target transaction, in order. The block takes a
// new target every cycle while the result side keeps up. A target passes
// through registered stages of difference, magnitude and squaring, the sum of
// squares, the square root pipeline (one root bit a stage), the pan and tilt
// cordics that run side by side, mount correction and wrapping, and the head
// code units. A stall at the output freezes the whole pipeline at once, so
// nothing is lost or repeated; ready follows the output register
// combinationally. Camera position and mount angle are written through the
// cfg port; the user must do so only while no transaction is in flight, as
// the block itself does not enforce this.
`default_nettype none

module camera_pan_tilt_pointing #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  cpt_in_if.sink                                   in_ch,
  cpt_out_if.source                                out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [cpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cpt_pkg::POS_W-1:0]           cfg_wdata
);

  localparam int DW = cpt_pkg::DIFF_W;
  localparam int MW = cpt_pkg::MAG_W;

  // geometry that rides alongside the square root
  typedef struct packed {
    logic [MW-1:0] ax;
    logic [MW-1:0] ay;
    logic [MW-1:0] az;
    logic          dx_neg;
    logic          dy_neg;
    logic          dz_neg;
    logic          dx_zero;
    logic          dy_zero;
    logic          az_zero;
    logic          xy_zero;
  } geo_t;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic dy_zero;
    logic xy_zero;
  } pan_flag_t;

  typedef struct packed {
    logic dz_neg;
    logic az_zero;
    logic xy_zero;
  } tilt_flag_t;

  // configuration registers
  logic signed [cpt_pkg::POS_W-1:0]   cam_x_r, cam_y_r, cam_z_r;
  logic signed [cpt_pkg::MOUNT_W-1:0] mount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      mount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpt_pkg::REG_CAM_X: cam_x_r <= cfg_wdata;
        cpt_pkg::REG_CAM_Y: cam_y_r <= cfg_wdata;
        cpt_pkg::REG_CAM_Z: cam_z_r <= cfg_wdata;
        cpt_pkg::REG_MOUNT: mount_r <= cfg_wdata[cpt_pkg::MOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished result is held up
  logic adv;
  logic pcode_vld, tcode_vld;
  assign adv         = !(pcode_vld && tcode_vld) || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: target minus camera
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= {in_ch.target_x[23], in_ch.target_x} - {cam_x_r[23], cam_x_r};
      dy_r <= {in_ch.target_y[23], in_ch.target_y} - {cam_y_r[23], cam_y_r};
      dz_r <= {in_ch.target_z[23], in_ch.target_z} - {cam_z_r[23], cam_z_r};
    end
  end

  // stage 2: magnitudes and the special-case flags
  geo_t geo2_nxt, geo2_r;
  logic v2_r;

  always_comb begin
    geo2_nxt.ax      = dx_r[DW-1] ? MW'(-dx_r) : dx_r[MW-1:0];
    geo2_nxt.ay      = dy_r[DW-1] ? MW'(-dy_r) : dy_r[MW-1:0];
    geo2_nxt.az      = dz_r[DW-1] ? MW'(-dz_r) : dz_r[MW-1:0];
    geo2_nxt.dx_neg  = dx_r[DW-1];
    geo2_nxt.dy_neg  = dy_r[DW-1];
    geo2_nxt.dz_neg  = dz_r[DW-1];
    geo2_nxt.dx_zero = (dx_r == '0);
    geo2_nxt.dy_zero = (dy_r == '0);
    geo2_nxt.az_zero = (dz_r == '0);
    geo2_nxt.xy_zero = (dx_r == '0) && (dy_r == '0);
  end

  // stage 3: squares
  logic [2*MW-1:0] sqx_r, sqy_r;
  geo_t            geo3_r;
  logic            v3_r;

  // stage 4: sum of squares
  logic [2*MW:0] sum_r;
  geo_t          geo4_r;
  logic          v4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      geo2_r <= geo2_nxt;
      sqx_r  <= (2*MW)'(geo2_r.ax) * (2*MW)'(geo2_r.ax);
      sqy_r  <= (2*MW)'(geo2_r.ay) * (2*MW)'(geo2_r.ay);
      geo3_r <= geo2_r;
      sum_r  <= (2*MW+1)'(sqx_r) + (2*MW+1)'(sqy_r);
      geo4_r <= geo3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // horizontal distance in mm*64: sqrt of the sum of squares times 4096
  logic [cpt_pkg::SQ_W-1:0]   radicand;
  logic                       sq_vld;
  logic [cpt_pkg::ROOT_W-1:0] hdist;
  geo_t                       geo_sq;

  assign radicand = {1'b0, sum_r, 12'd0};

  cpt_isqrt #(
    .SW ($bits(geo_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v4_r),
    .in_val   (radicand),
    .in_side  (geo4_r),
    .out_vld  (sq_vld),
    .out_root (hdist),
    .out_side (geo_sq)
  );

  // pan and tilt cordics side by side, operands in mm*64
  pan_flag_t  pan_fl_in, pan_fl;
  tilt_flag_t tilt_fl_in, tilt_fl;
  logic       pan_c_vld, tilt_c_vld;
  logic [cpt_pkg::ANG_W-1:0] pan_ang, tilt_ang;

  assign pan_fl_in  = '{dx_neg: geo_sq.dx_neg, dy_neg: geo_sq.dy_neg,
                        dx_zero: geo_sq.dx_zero, dy_zero: geo_sq.dy_zero,
                        xy_zero: geo_sq.xy_zero};
  assign tilt_fl_in = '{dz_neg: geo_sq.dz_neg, az_zero: geo_sq.az_zero,
                        xy_zero: geo_sq.xy_zero};

  cpt_cordic #(
    .STEPS (CORDIC_STEPS),
    .SW    ($bits(pan_flag_t))
  ) u_cordic_pan (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (sq_vld),
    .in_x     ({1'b0, geo_sq.ax, 6'd0}),
    .in_y     ({1'b0, geo_sq.ay, 6'd0}),
    .in_side  (pan_fl_in),
    .out_vld  (pan_c_vld),
    .out_ang  (pan_ang),
    .out_side (pan_fl)
  );

  cpt_cordic #(
    .STEPS (CORDIC_STEPS),
    .SW    ($bits(tilt_flag_t))
  ) u_cordic_tilt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (sq_vld),
    .in_x     (hdist),
    .in_y     ({1'b0, geo_sq.az, 6'd0}),
    .in_side  (tilt_fl_in),
    .out_vld  (tilt_c_vld),
    .out_ang  (tilt_ang),
    .out_side (tilt_fl)
  );

  // quadrant fix-up, mount correction, single wrap and saturation
  logic signed [18:0] pa, pan_raw, pan_m, pan_w;
  logic signed [cpt_pkg::PAN_W-1:0]  pan_deg_nxt, pan_deg_r;
  logic signed [cpt_pkg::TILT_W-1:0] ta, tilt_deg_nxt, tilt_deg_r;
  logic v5_r;

  always_comb begin
    // axis cases come out exact, not from the cordic
    if (pan_fl.dy_zero) begin
      pa = '0;
    end else if (pan_fl.dx_zero) begin
      pa = 19'(cpt_pkg::DEG90);
    end else begin
      pa = $signed({4'd0, pan_ang});
    end
    if (pan_fl.dx_neg) begin
      pa = 19'(cpt_pkg::DEG180) - pa;
    end
    // target on the camera gives zero, straight behind gives minus half turn
    if (pan_fl.xy_zero) begin
      pan_raw = '0;
    end else if (pan_fl.dx_neg && pan_fl.dy_zero) begin
      pan_raw = -19'(cpt_pkg::DEG180);
    end else if (pan_fl.dy_neg) begin
      pan_raw = -pa;
    end else begin
      pan_raw = pa;
    end
    pan_m = pan_raw - {{2{mount_r[cpt_pkg::MOUNT_W-1]}}, mount_r};
    if (pan_m > 19'(cpt_pkg::DEG180)) begin
      pan_w = pan_m - 19'(cpt_pkg::DEG360);
    end else if (pan_m < -19'(cpt_pkg::DEG180)) begin
      pan_w = pan_m + 19'(cpt_pkg::DEG360);
    end else begin
      pan_w = pan_m;
    end
    if (pan_w > 19'(cpt_pkg::DEG180)) begin
      pan_w = 19'(cpt_pkg::DEG180);
    end else if (pan_w < -19'(cpt_pkg::DEG180)) begin
      pan_w = -19'(cpt_pkg::DEG180);
    end
    pan_deg_nxt = pan_w[cpt_pkg::PAN_W-1:0];

    // vertical line of sight gives a quarter turn by the sign of dz
    if (tilt_fl.az_zero) begin
      ta = '0;
    end else if (tilt_fl.xy_zero) begin
      ta = 16'(cpt_pkg::DEG90);
    end else begin
      ta = $signed({1'b0, tilt_ang});
    end
    tilt_deg_nxt = tilt_fl.dz_neg ? -ta : ta;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_deg_r  <= pan_deg_nxt;
      tilt_deg_r <= tilt_deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= pan_c_vld && tilt_c_vld;
    end
  end

  // head codes, the last stage of each doubles as the output register
  logic [cpt_pkg::CODE_W-1:0]        pan_code, tilt_code;
  logic signed [cpt_pkg::PAN_W-1:0]  pan_deg_o;
  logic signed [cpt_pkg::TILT_W-1:0] tilt_deg_o;

  cpt_code #(
    .AW   (cpt_pkg::PAN_W),
    .BASE (cpt_pkg::PAN_BASE),
    .OFF  (cpt_pkg::PAN_OFF),
    .SPAN (cpt_pkg::PAN_SPAN),
    .ZERO (cpt_pkg::PAN_ZERO),
    .SW   (cpt_pkg::PAN_W)
  ) u_code_pan (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v5_r),
    .in_ang   (pan_deg_r),
    .in_side  (pan_deg_r),
    .out_vld  (pcode_vld),
    .out_code (pan_code),
    .out_side (pan_deg_o)
  );

  cpt_code #(
    .AW   (cpt_pkg::TILT_W),
    .BASE (cpt_pkg::TILT_BASE),
    .OFF  (cpt_pkg::TILT_OFF),
    .SPAN (cpt_pkg::TILT_SPAN),
    .ZERO (cpt_pkg::TILT_ZERO),
    .SW   (cpt_pkg::TILT_W)
  ) u_code_tilt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v5_r),
    .in_ang   (tilt_deg_r),
    .in_side  (tilt_deg_r),
    .out_vld  (tcode_vld),
    .out_code (tilt_code),
    .out_side (tilt_deg_o)
  );

  assign out_ch.valid     = pcode_vld && tcode_vld;
  assign out_ch.pan_deg   = pan_deg_o;
  assign out_ch.tilt_deg  = tilt_deg_o;
  assign out_ch.pan_code  = pan_code;
  assign out_ch.tilt_code = tilt_code;

endmodule

`default_nettype wire

@@ sv/cpt_isqrt.sv @@
// ---------------------------------------------------------------------------
// cpt_isqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module cpt_isqrt #(
  parameter int SW = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [cpt_pkg::SQ_W-1:0]    in_val,
  input  wire logic [SW-1:0]               in_side,
  output logic                             out_vld,
  output logic [cpt_pkg::ROOT_W-1:0]       out_root,
  output logic [SW-1:0]                    out_side
);

  localparam int VW = cpt_pkg::SQ_W;
  localparam int N  = VW / 2;

  logic [VW-1:0] rem_r  [N];
  logic [VW-1:0] root_r [N];
  logic [SW-1:0] side_r [N];
  logic          vld_r  [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_st
    localparam logic [VW-1:0] BIT = {{(VW-1){1'b0}}, 1'b1} << (VW - 2 - 2 * k);
    logic [VW-1:0] rem_p, root_p, trial, rem_nxt, root_nxt;
    logic [SW-1:0] side_p;
    logic          vld_p;

    if (k == 0) begin : g_first
      assign rem_p  = in_val;
      assign root_p = '0;
      assign side_p = in_side;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign trial = root_p + BIT;

    always_comb begin
      if (rem_p >= trial) begin
        rem_nxt  = rem_p - trial;
        root_nxt = (root_p >> 1) + BIT;
      end else begin
        rem_nxt  = rem_p;
        root_nxt = root_p >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1][cpt_pkg::ROOT_W-1:0];
  assign out_side = side_r[N-1];

endmodule

`default_nettype wire

@@ sv/cpt_cordic.sv @@
// ---------------------------------------------------------------------------
// cpt_cordic
// unrolled vectoring cordic, first quadrant angle of (x, y) in degrees*256
// ---------------------------------------------------------------------------
`default_nettype none

module cpt_cordic #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [cpt_pkg::ROOT_W-1:0]  in_x,
  input  wire logic [cpt_pkg::ROOT_W-1:0]  in_y,
  input  wire logic [SW-1:0]               in_side,
  output logic                             out_vld,
  output logic [cpt_pkg::ANG_W-1:0]        out_ang,
  output logic [SW-1:0]                    out_side
);

  localparam int XW = cpt_pkg::CX_W;
  localparam int ZW = cpt_pkg::CZ_W;
  localparam logic signed [ZW-1:0] FINE = ZW'(cpt_pkg::DEG90_FINE);

  logic signed [XW-1:0] x_r [STEPS];
  logic signed [XW-1:0] y_r [STEPS];
  logic signed [ZW-1:0] z_r [STEPS];
  logic [SW-1:0]        side_r [STEPS];
  logic                 vld_r [STEPS];

  genvar i;
  for (i = 0; i < STEPS; i++) begin : g_it
    logic signed [XW-1:0] x_p, y_p, xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_p, z_nxt;
    logic [SW-1:0]        side_p;
    logic                 vld_p;

    if (i == 0) begin : g_first
      assign x_p    = $signed({{(XW-cpt_pkg::ROOT_W){1'b0}}, in_x});
      assign y_p    = $signed({{(XW-cpt_pkg::ROOT_W){1'b0}}, in_y});
      assign z_p    = '0;
      assign side_p = in_side;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign x_p    = x_r[i-1];
      assign y_p    = y_r[i-1];
      assign z_p    = z_r[i-1];
      assign side_p = side_r[i-1];
      assign vld_p  = vld_r[i-1];
    end

    assign xs = x_p >>> i;
    assign ys = y_p >>> i;

    always_comb begin
      if (!y_p[XW-1]) begin
        x_nxt = x_p + ys;
        y_nxt = y_p - xs;
        z_nxt = z_p + cpt_pkg::atan_tab(i);
      end else begin
        x_nxt = x_p - ys;
        y_nxt = y_p + xs;
        z_nxt = z_p - cpt_pkg::atan_tab(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end
  end

  // clamp to 0..90 degrees, round half up to degrees*256
  logic signed [ZW-1:0] z_cl, z_rnd;
  logic [cpt_pkg::ANG_W-1:0] ang_r, ang_nxt;
  logic [SW-1:0]             side_o_r;
  logic                      vld_o_r;

  always_comb begin
    if (z_r[STEPS-1][ZW-1]) begin
      z_cl = '0;
    end else if (z_r[STEPS-1] > FINE) begin
      z_cl = FINE;
    end else begin
      z_cl = z_r[STEPS-1];
    end
    z_rnd   = z_cl + ZW'(128);
    ang_nxt = z_rnd[cpt_pkg::ANG_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r    <= ang_nxt;
      side_o_r <= side_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_o_r <= vld_r[STEPS-1];
    end
  end

  assign out_vld  = vld_o_r;
  assign out_ang  = ang_r;
  assign out_side = side_o_r;

endmodule

`default_nettype wire

@@ sv/cpt_code.sv @@
// ---------------------------------------------------------------------------
// cpt_code
// linear head code of an angle, exact integer form, truncated and saturated
// ---------------------------------------------------------------------------
`default_nettype none

module cpt_code #(
  parameter int AW    = 17,
  parameter int BASE  = 63700,
  parameter int OFF   = 175,
  parameter int SPAN  = 42476,
  parameter int ZERO  = 11529,
  parameter int SW    = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic signed [AW-1:0]        in_ang,
  input  wire logic [SW-1:0]               in_side,
  output logic                             out_vld,
  output logic [cpt_pkg::CODE_W-1:0]       out_code,
  output logic [SW-1:0]                    out_side
);

  localparam logic signed [31:0] D32    = 32'(BASE * 256);
  localparam logic signed [31:0] OFF32  = 32'(OFF * 256);
  localparam logic signed [31:0] SLOPE  = 32'(cpt_pkg::CODE_SLOPE);
  localparam logic signed [47:0] SPAN48 = 48'(SPAN);
  localparam logic signed [47:0] ZD48   = 48'(ZERO) * 48'(BASE * 256);
  localparam logic [65:0]        RECIP  = 66'((66'd1 << 48) / BASE);
  localparam logic [31:0]        BASE32 = 32'(BASE);

  // stage 1: numerator
  logic signed [31:0] a_ext, n_nxt, n_r;
  // stage 2: scaled numerator
  logic signed [47:0] n_ext, t_nxt, t_r;
  // stage 3: quotient estimate by reciprocal
  logic [31:0] u_nxt, u_r;
  logic [65:0] prod;
  logic [16:0] qe_r;
  logic        neg3_r;
  // stage 4: remainder
  logic [31:0] qb, r_full;
  logic [17:0] r_r;
  logic [16:0] qe4_r;
  logic        neg4_r;
  // stage 5: correction
  logic [17:0] q;
  logic [cpt_pkg::CODE_W-1:0] code_nxt, code_r;

  logic [SW-1:0] side_r [5];
  logic          vld_r  [5];

  assign a_ext = {{(32-AW){in_ang[AW-1]}}, in_ang};
  assign n_nxt = D32 - (a_ext + OFF32) * SLOPE;

  assign n_ext = {{16{n_r[31]}}, n_r};
  assign t_nxt = n_ext * SPAN48 + ZD48;

  assign u_nxt = t_r[39:8];
  assign prod  = {34'd0, u_nxt} * RECIP;

  assign qb     = {15'd0, qe_r} * BASE32;
  assign r_full = u_r - qb;

  always_comb begin
    q = {1'b0, qe4_r} + ((r_r >= BASE32[17:0]) ? 18'd1 : 18'd0);
    if (neg4_r) begin
      code_nxt = '0;
    end else if (q > 18'd65535) begin
      code_nxt = '1;
    end else begin
      code_nxt = q[cpt_pkg::CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      t_r    <= t_nxt;
      u_r    <= u_nxt;
      qe_r   <= prod[64:48];
      neg3_r <= t_r[47];
      r_r    <= r_full[17:0];
      qe4_r  <= qe_r;
      neg4_r <= neg3_r;
      code_r <= code_nxt;
      side_r[0] <= in_side;
      for (int s = 1; s < 5; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 5; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < 5; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[4];
  assign out_code = code_r;
  assign out_side = side_r[4];

endmodule

`default_nettype wire

@@ sv/cpt_checker.sv @@
// ---------------------------------------------------------------------------
// cpt_checker
// port-level checks on the pointing unit, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module cpt_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [cpt_pkg::PAN_W-1:0]    out_pan_deg,
  input wire logic signed [cpt_pkg::TILT_W-1:0]   out_tilt_deg,
  input wire logic        [cpt_pkg::CODE_W-1:0]   out_pan_code,
  input wire logic        [cpt_pkg::CODE_W-1:0]   out_tilt_code
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pan_deg)
      && $stable(out_tilt_deg) && $stable(out_pan_code) && $stable(out_tilt_code))
    else $error("result changed while stalled");

  // input side only waits on a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow the output stall");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pan_deg <= 17'sd46080) && (out_pan_deg >= -17'sd46080))
    else $error("pan out of range");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tilt_deg <= 16'sd23040) && (out_tilt_deg >= -16'sd23040))
    else $error("tilt out of range");

endmodule

bind camera_pan_tilt_pointing cpt_checker u_cpt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pan_deg   (out_ch.pan_deg),
  .out_tilt_deg  (out_ch.tilt_deg),
  .out_pan_code  (out_ch.pan_code),
  .out_tilt_code (out_ch.tilt_code)
);

`default_nettype wire
